// ===== rtl/lerb_pkg.sv =====
// Shared types and constants for the line edit receive buffer.
// Used by lerb_front, lerb_queue, lerb_back and line_edit_receive_buffer.
// No dependencies.
package lerb_pkg;

  localparam int BYTE_W  = 8;
  localparam int LIMIT_W = 7;
  localparam int COUNT_W = 7;

  localparam logic [BYTE_W-1:0] NL_CHAR = 8'h0A;
  localparam logic [BYTE_W-1:0] BS_CHAR = 8'h08;
  localparam logic [BYTE_W-1:0] SP_CHAR = 8'h20;

  typedef enum logic {
    MODE_RX   = 1'b0,
    MODE_READ = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    KIND_ECHO      = 2'd0,
    KIND_LINE      = 2'd1,
    KIND_EMPTY     = 2'd2,
    KIND_NOT_READY = 2'd3
  } kind_t;

  // Class of a command once the front end has decoded it
  typedef enum logic [1:0] {
    OP_CHAR = 2'd0,
    OP_NL   = 2'd1,
    OP_BS   = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_BS1  = 2'd1,
    S_BS2  = 2'd2,
    S_READ = 2'd3
  } back_state_t;

  typedef struct packed {
    logic               mode;
    logic [BYTE_W-1:0]  rx_byte;
    logic [LIMIT_W-1:0] read_limit;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [COUNT_W-1:0] byte_count;
    logic               last;
  } result_t;

  typedef struct packed {
    op_t                op;
    logic [BYTE_W-1:0]  data;
    logic [LIMIT_W-1:0] limit;
  } cmd_t;

endpackage

// ===== rtl/lerb_front.sv =====
// Front end: takes input items, decodes them into commands and pushes
// them into the command queue. Depends on lerb_pkg.
module lerb_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  lerb_pkg::item_t item,
  output logic           busy,
  output lerb_pkg::cmd_t cmd,
  output logic           push,
  input  logic           full
);
  import lerb_pkg::*;

  logic  valid;
  logic  valid_next;
  logic  take;
  cmd_t  cmd_dec;

  always_comb begin
    cmd_dec.data  = item.rx_byte;
    cmd_dec.limit = item.read_limit;
    if (item.mode == MODE_READ) begin
      cmd_dec.op = OP_READ;
    end else if (item.rx_byte == NL_CHAR) begin
      cmd_dec.op = OP_NL;
    end else if (item.rx_byte == BS_CHAR) begin
      cmd_dec.op = OP_BS;
    end else begin
      cmd_dec.op = OP_CHAR;
    end
  end

  assign push = valid && !full;
  assign busy = valid && full;
  assign take = start && !busy;

  always_comb begin
    valid_next = valid;
    if (take) begin
      valid_next = 1'b1;
    end else if (push) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= cmd_dec;
    end
  end

endmodule

// ===== rtl/lerb_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on lerb_pkg for the command type.
module lerb_queue #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lerb_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output lerb_pkg::cmd_t head,
  output logic           empty
);
  import lerb_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

// ===== rtl/lerb_back.sv =====
// Back end: owns the line store, fill index and ready mark, and turns
// queued commands into echo, line and status results. Depends on lerb_pkg.
module lerb_back #(
  parameter int LINE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  lerb_pkg::cmd_t    cmd,
  input  logic              empty,
  output logic              pop,
  output logic              strobe,
  output lerb_pkg::result_t result
);
  import lerb_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int CW = $clog2(LINE_DEPTH + 1);

  logic [BYTE_W-1:0] line_mem [LINE_DEPTH];
  logic [BYTE_W-1:0] rdata;

  back_state_t   state;
  back_state_t   state_next;
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic          ready;
  logic          ready_next;
  logic [CW-1:0] n;
  logic [CW-1:0] n_next;
  logic [AW-1:0] idx;
  logic [AW-1:0] idx_next;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic          strobe_next;
  result_t       result_next;

  logic               store_full;
  logic               bs_erase;
  logic               idx_last;
  logic [COUNT_W-1:0] fill_ext;
  logic [COUNT_W-1:0] n_calc;

  assign store_full = (fill >= CW'(LINE_DEPTH));
  assign bs_erase   = (cmd.op == OP_BS) && (fill != '0);
  assign idx_last   = ((CW'(idx) + CW'(1)) == n);
  assign fill_ext   = COUNT_W'(fill);
  assign n_calc     = (fill_ext < cmd.limit) ? fill_ext : cmd.limit;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!empty) begin
          if (cmd.op == OP_READ) begin
            if (ready && (n_calc != '0)) begin
              state_next = S_READ;
            end
          end else if (!store_full && bs_erase) begin
            state_next = S_BS1;
          end
        end
      end
      S_BS1:   state_next = S_BS2;
      S_BS2:   state_next = S_IDLE;
      S_READ: begin
        if (idx_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    pop         = 1'b0;
    wr_en       = 1'b0;
    rd_addr     = '0;
    fill_next   = fill;
    ready_next  = ready;
    n_next      = n;
    idx_next    = idx;
    strobe_next = 1'b0;
    result_next = '0;
    case (state)
      S_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (cmd.op == OP_READ) begin
            if (!ready) begin
              strobe_next      = 1'b1;
              result_next.kind = KIND_NOT_READY;
              result_next.last = 1'b1;
            end else begin
              ready_next = 1'b0;
              fill_next  = '0;
              if (n_calc == '0) begin
                strobe_next      = 1'b1;
                result_next.kind = KIND_EMPTY;
                result_next.last = 1'b1;
              end else begin
                n_next   = CW'(n_calc);
                idx_next = '0;
              end
            end
          end else if (!store_full) begin
            strobe_next      = 1'b1;
            result_next.kind = KIND_ECHO;
            if (bs_erase) begin
              result_next.data_byte = BS_CHAR;
              fill_next             = fill - CW'(1);
            end else begin
              result_next.data_byte = cmd.data;
              result_next.last      = 1'b1;
              wr_en                 = 1'b1;
              fill_next             = fill + CW'(1);
              if (cmd.op == OP_NL) begin
                ready_next = 1'b1;
              end
            end
          end
        end
      end
      S_BS1: begin
        strobe_next           = 1'b1;
        result_next.kind      = KIND_ECHO;
        result_next.data_byte = SP_CHAR;
      end
      S_BS2: begin
        strobe_next           = 1'b1;
        result_next.kind      = KIND_ECHO;
        result_next.data_byte = BS_CHAR;
        result_next.last      = 1'b1;
      end
      S_READ: begin
        strobe_next            = 1'b1;
        result_next.kind       = KIND_LINE;
        result_next.data_byte  = rdata;
        result_next.byte_count = COUNT_W'(n);
        result_next.last       = idx_last;
        idx_next               = idx + AW'(1);
        // prefetch the following entry; rdata is the registered read of rd_addr
        rd_addr                = idx_last ? '0 : idx + AW'(1);
      end
      default: begin
        strobe_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      fill   <= '0;
      ready  <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      ready  <= ready_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    n      <= n_next;
    idx    <= idx_next;
    result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[fill[AW-1:0]] <= cmd.data;
    end
    rdata <= line_mem[rd_addr];
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(LINE_DEPTH)) else $error("fill index past line depth");
  a_read_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (n != '0) && (CW'(idx) < n))
    else $error("read index outside line");
  a_bs_seq: assert property (@(posedge clk) disable iff (rst)
    (state == S_BS1) |=> (state == S_BS2) && strobe
      && (result.data_byte == SP_CHAR))
    else $error("backspace echo sequence broken");
  a_strobe_cause: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(pop) || $past(state != S_IDLE))
    else $error("result without a command");
  a_read_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (fill == '0) && !ready)
    else $error("line state not cleared during read");

endmodule

// ===== rtl/line_edit_receive_buffer.sv =====
// Line edit receive buffer: serial line editor with backspace echo.
// Top level; ties lerb_front, lerb_queue and lerb_back. Depends on lerb_pkg.
//
//   channel   handshake            payload   direction
//   command   start / busy         item      in
//   result    strobe (one cycle)   result    out
//
// A received byte is echoed, or dropped while the line store is full; a
// backspace that erases echoes backspace, space, backspace; a read of n
// bytes gives n line results via the back-end sequencer and registered
// line store read port. Items pass the front register and queue first.
// Reset clears the queue, fill index, ready mark and sequencer; the line
// store is not cleared. busy rises only while the queue and the front
// register are both full; results cannot be stalled.
module line_edit_receive_buffer #(
  parameter int LINE_DEPTH  = 64,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  lerb_pkg::item_t   item,
  output logic              strobe,
  output lerb_pkg::result_t result
);
  import lerb_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic push;
  logic full;
  logic pop;
  logic empty;

  lerb_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .cmd   (front_cmd),
    .push  (push),
    .full  (full)
  );

  lerb_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head_cmd),
    .empty    (empty)
  );

  lerb_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cmd    (head_cmd),
    .empty  (empty),
    .pop    (pop),
    .strobe (strobe),
    .result (result)
  );

endmodule

// ===== test/line_edit_receive_buffer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for line_edit_receive_buffer: sends received bytes and read
// requests, predicts echo and line results, and checks every strobed result in order.
// Depends on lerb_pkg and the line_edit_receive_buffer RTL.
module line_edit_receive_buffer_tb;
  import lerb_pkg::*;

  localparam int LINE_DEPTH  = 64;
  localparam int HOLD_QUIET  = 4;
  localparam int DRAIN_WAIT  = 100;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_BUDGET = 480;

  typedef struct {
    item_t cmd;
    bit    hold;  // wait until every expected result is in before this transfer
  } pending_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  item_t   item = '0;
  logic    strobe;
  result_t result;

  pending_t cmd_queue[$];
  result_t  expected_results[$];

  // editor state as the testbench sees it
  logic [BYTE_W-1:0] line_copy[LINE_DEPTH];
  int unsigned       line_fill = 0;
  bit                line_marked = 1'b0;

  // stimulus-side view of fill and ready, only to know which bytes get dropped
  int unsigned gen_fill = 0;
  bit          gen_ready = 1'b0;
  bit          hold_next = 1'b0;
  int unsigned n_queued = 0;

  int unsigned mismatches = 0;
  int unsigned n_accepted = 0, n_checked = 0, n_dropped = 0, n_erase = 0;
  int unsigned n_not_ready = 0, n_empty = 0, n_lines = 0;
  int unsigned cycles = 0;

  int unsigned gap_left = 0, burst_left = 0, quiet = 0;
  pending_t    nxt;
  result_t     want;

  line_edit_receive_buffer #(.LINE_DEPTH(LINE_DEPTH)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string what, input result_t got, input result_t exp_r);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t mismatch, %s: got kind=%0d data=%02h count=%0d last=%0b,",
               $time, what, got.kind, got.data_byte, got.byte_count, got.last,
               " want kind=%0d data=%02h count=%0d last=%0b",
               exp_r.kind, exp_r.data_byte, exp_r.byte_count, exp_r.last);
    end
  endtask

  function automatic result_t editor_result(input kind_t k, input logic [BYTE_W-1:0] d,
                                            input logic [COUNT_W-1:0] c, input logic l);
    result_t r;
    r.kind       = k;
    r.data_byte  = d;
    r.byte_count = c;
    r.last       = l;
    return r;
  endfunction

  task automatic predict_editor(input item_t it);
    int unsigned n;
    if (it.mode == MODE_RX) begin
      if (line_fill >= LINE_DEPTH) begin
        n_dropped++;
      end else if (it.rx_byte == BS_CHAR && line_fill > 0) begin
        expected_results.push_back(editor_result(KIND_ECHO, BS_CHAR, '0, 1'b0));
        expected_results.push_back(editor_result(KIND_ECHO, SP_CHAR, '0, 1'b0));
        expected_results.push_back(editor_result(KIND_ECHO, BS_CHAR, '0, 1'b1));
        line_fill--;
        n_erase++;
      end else begin
        if (it.rx_byte == NL_CHAR) line_marked = 1'b1;
        expected_results.push_back(editor_result(KIND_ECHO, it.rx_byte, '0, 1'b1));
        line_copy[line_fill] = it.rx_byte;
        line_fill++;
      end
    end else if (!line_marked) begin
      expected_results.push_back(editor_result(KIND_NOT_READY, '0, '0, 1'b1));
      n_not_ready++;
    end else begin
      n = (line_fill < it.read_limit) ? line_fill : it.read_limit;
      line_marked = 1'b0;
      line_fill   = 0;
      if (n == 0) begin
        expected_results.push_back(editor_result(KIND_EMPTY, '0, '0, 1'b1));
        n_empty++;
      end else begin
        for (int i = 0; i < n; i++) begin
          expected_results.push_back(editor_result(KIND_LINE, line_copy[i], n[COUNT_W-1:0],
                                                   (i == n - 1)));
        end
        n_lines++;
      end
    end
  endtask

  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    pending_t p;
    p.cmd.mode       = MODE_RX;
    p.cmd.rx_byte    = b;
    p.cmd.read_limit = LIMIT_W'($urandom_range(0, LINE_DEPTH));  // unused field
    p.hold           = hold_next;
    hold_next        = 1'b0;
    cmd_queue.push_back(p);
    if (gen_fill < LINE_DEPTH) begin
      n_queued++;
      if (b == BS_CHAR && gen_fill > 0) begin
        gen_fill--;
      end else begin
        gen_fill++;
        if (b == NL_CHAR) gen_ready = 1'b1;
      end
    end
  endtask

  task automatic queue_read(input logic [LIMIT_W-1:0] limit);
    pending_t p;
    p.cmd.mode       = MODE_READ;
    p.cmd.rx_byte    = BYTE_W'($urandom_range(0, 255));
    p.cmd.read_limit = limit;
    p.hold           = hold_next;
    hold_next        = 1'b0;
    cmd_queue.push_back(p);
    n_queued++;
    if (gen_ready) begin
      gen_ready = 1'b0;
      gen_fill  = 0;
    end
  endtask

  // line content: any byte but backspace, often printable
  function automatic logic [BYTE_W-1:0] line_char();
    logic [BYTE_W-1:0] c;
    c = BYTE_W'(($urandom_range(0, 3) == 0) ? $urandom_range(32, 126)
                                             : $urandom_range(0, 255));
    return (c == BS_CHAR) ? BS_CHAR + 8'd1 : c;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_editor(item);
        n_accepted++;
        if (burst_left > 0) begin
          burst_left--;
          gap_left = 0;
        end else if ($urandom_range(0, 11) == 0) begin
          burst_left = $urandom_range(8, 40);
          gap_left   = 0;
        end else begin
          gap_left = $urandom_range(0, 6);
        end
      end
      quiet = (strobe || (start && !busy)) ? 0 : quiet + 1;
      if (start && busy) begin
        // keep the item up until the transfer
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_queue.size() > 0 &&
                   !(cmd_queue[0].hold &&
                     (expected_results.size() > 0 || quiet < HOLD_QUIET))) begin
        nxt = cmd_queue.pop_front();
        item  <= nxt.cmd;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && strobe !== 1'b0) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("result with nothing expected", result, '0);
      end else begin
        want = expected_results.pop_front();
        if (result.kind !== want.kind || result.data_byte !== want.data_byte ||
            result.byte_count !== want.byte_count || result.last !== want.last) begin
          flag_mismatch("wrong field", result, want);
        end
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned pick, len;

    // directed part
    queue_read(LIMIT_W'(LINE_DEPTH));   // nothing ready yet
    queue_byte(BS_CHAR);          // backspace on empty line is stored
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(BS_CHAR);          // erases 0xFF
    queue_byte(8'h55);
    queue_byte(8'hAA);
    queue_byte(NL_CHAR);
    queue_read(7'd1);             // truncated read
    queue_read(LIMIT_W'(LINE_DEPTH));   // mark was cleared
    queue_byte(NL_CHAR);
    queue_read(7'd0);             // zero limit gives empty read
    queue_byte(8'h41);
    queue_byte(NL_CHAR);
    queue_byte(BS_CHAR);          // erases the newline, line stays ready
    queue_read(7'd63);
    queue_byte(NL_CHAR);
    queue_byte(BS_CHAR);
    queue_read(7'd42);            // ready but nothing stored
    queue_byte(8'h7F);
    queue_byte(NL_CHAR);
    queue_read(LIMIT_W'(LINE_DEPTH));

    // fill the store, then bytes past the end are dropped
    hold_next = 1'b1;
    repeat (30) queue_byte(line_char());
    queue_byte(NL_CHAR);
    while (gen_fill < LINE_DEPTH) queue_byte(line_char());
    queue_byte(NL_CHAR);
    queue_byte(BS_CHAR);
    queue_byte(8'h41);
    queue_read(LIMIT_W'(LINE_DEPTH));

    // random part: mostly edited lines followed by a read
    while (n_queued < ITEM_BUDGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) hold_next = 1'b1;
      if (pick < 72) begin
        len = $urandom_range(0, 12);
        repeat (len) queue_byte(($urandom_range(0, 7) == 0) ? BS_CHAR : line_char());
        if ($urandom_range(0, 5) == 0) queue_read(LIMIT_W'($urandom_range(0, LINE_DEPTH)));
        queue_byte(NL_CHAR);
        if ($urandom_range(0, 7) == 0) queue_byte(BS_CHAR);
        case ($urandom_range(0, 3))
          0: queue_read(LIMIT_W'(LINE_DEPTH));
          1: queue_read(LIMIT_W'($urandom_range(0, len)));
          2: queue_read(LIMIT_W'($urandom_range(0, LINE_DEPTH)));
          default: queue_read(LIMIT_W'(len + 1));
        endcase
      end else if (pick < 77) begin
        len = $urandom_range(40, LINE_DEPTH + 4);
        repeat (len) queue_byte(line_char());
        queue_byte(NL_CHAR);
        queue_read(LIMIT_W'($urandom_range(0, LINE_DEPTH)));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 0) queue_byte(BYTE_W'($urandom_range(0, 255)));
          else queue_read(LIMIT_W'($urandom_range(0, LINE_DEPTH)));
        end
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() > 0 || start) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_results.size() > 0) begin
      flag_mismatch($sformatf("%0d results never came", expected_results.size()),
                    '0, expected_results[0]);
    end

    $display("run: %0d transfers, %0d results checked, %0d erases, %0d dropped on full line",
             n_accepted, n_checked, n_erase, n_dropped);
    $display("reads: %0d lines delivered, %0d empty, %0d not ready; %0d mismatches",
             n_lines, n_empty, n_not_ready, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lerb_pkg.sv
rtl/lerb_front.sv
rtl/lerb_queue.sv
rtl/lerb_back.sv
rtl/line_edit_receive_buffer.sv
test/line_edit_receive_buffer_tb.sv
